>>> rtl/mbsb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the monochrome bitmap scaled blitter.
// No dependencies; every other file of the block refers to it by scoped names.
package mbsb_pkg;

   localparam int FB_BYTES_DEF = 4096;

   localparam int OP_W        = 2;
   localparam int BYTE_W      = 8;
   localparam int ROW_W       = 8;
   localparam int COLB_W      = 5;
   localparam int RADDR_W     = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int PAT_W       = 16;
   localparam int WIN_W       = 24;
   localparam int XW          = 10;
   localparam int YW          = 10;
   localparam int BX_W        = 7;
   localparam int YROW_W      = 11;
   localparam int BASE_W      = 17;
   localparam int ACALC_W     = 18;
   localparam int CLR_PROD_W  = 15;
   localparam int SLOT_W      = 3;
   localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;
   localparam logic [SLOT_W-1:0] SLOTS_ROW = 3'd3;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [1:0] SCALE_ONE  = 2'd0;
   localparam logic [1:0] SCALE_HALF = 2'd1;
   localparam logic [1:0] SCALE_TWO  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_COL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_ROW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_STRIDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB_ROWS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROWS    = 3'd6;

   typedef struct packed {
      logic [7:0] origin_col;
      logic [7:0] origin_row;
      logic [1:0] scale_mode;
      logic [6:0] row_stride_bytes;
      logic [7:0] fb_rows;
      logic [5:0] src_width_bytes;
      logic [7:0] src_rows;
   } csr_regs_type;

   localparam csr_regs_type CSR_RESET = '{
      origin_col:       8'd0,
      origin_row:       8'd0,
      scale_mode:       SCALE_ONE,
      row_stride_bytes: 7'd20,
      fb_rows:          8'd168,
      src_width_bytes:  6'd2,
      src_rows:         8'd16
   };

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLR_SIZE,
      ST_CLR,
      ST_DRAW_PREP,
      ST_DRAW_BASE,
      ST_DRAW_WALK,
      ST_DRAW_DRAIN,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_DONE
   } ctrl_state_type;

endpackage

>>> rtl/mbsb_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the blitter (valid/ready words).
// Depends on mbsb_pkg for field widths.
interface mbsb_req_if;
   logic                              valid;
   logic                              ready;
   logic [mbsb_pkg::OP_W-1:0]         op;
   logic [mbsb_pkg::BYTE_W-1:0]       src_byte;
   logic [mbsb_pkg::ROW_W-1:0]        src_row;
   logic [mbsb_pkg::COLB_W-1:0]       src_col_byte;
   logic [mbsb_pkg::RADDR_W-1:0]      read_addr;

   modport source (output valid, output op, output src_byte, output src_row,
                   output src_col_byte, output read_addr, input ready);
   modport sink   (input valid, input op, input src_byte, input src_row,
                   input src_col_byte, input read_addr, output ready);
endinterface

interface mbsb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mbsb_pkg::BYTE_W-1:0]       read_data;
   logic                              status;

   modport source (output valid, output read_data, output status, input ready);
   modport sink   (input valid, input read_data, input status, output ready);
endinterface

>>> rtl/mbsb_csr.sv
`timescale 1ns / 1ps
// Configuration register file of the blitter, written through a plain write port.
// Depends on mbsb_pkg for the register struct, indexes and reset values.
module mbsb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbsb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbsb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mbsb_pkg::csr_regs_type              regs
);

   mbsb_pkg::csr_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         unique case (csr_index)
            mbsb_pkg::REG_ORIGIN_COL: regs_in.origin_col       = csr_wdata;
            mbsb_pkg::REG_ORIGIN_ROW: regs_in.origin_row       = csr_wdata;
            mbsb_pkg::REG_SCALE_MODE: regs_in.scale_mode       = csr_wdata[1:0];
            mbsb_pkg::REG_ROW_STRIDE: regs_in.row_stride_bytes = csr_wdata[6:0];
            mbsb_pkg::REG_FB_ROWS:    regs_in.fb_rows          = csr_wdata;
            mbsb_pkg::REG_SRC_WIDTH:  regs_in.src_width_bytes  = csr_wdata[5:0];
            mbsb_pkg::REG_SRC_ROWS:   regs_in.src_rows         = csr_wdata;
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= mbsb_pkg::CSR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

>>> rtl/mbsb_frame_mem.sv
`timescale 1ns / 1ps
// Framebuffer byte store: one write port, one read port with registered read data.
// Depends on mbsb_pkg for the byte width.
module mbsb_frame_mem #(
   parameter int DEPTH = mbsb_pkg::FB_BYTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [AW-1:0]                     waddr,
   input  logic [mbsb_pkg::BYTE_W-1:0]       wdata,
   input  logic                              re,
   input  logic [AW-1:0]                     raddr,
   output logic [mbsb_pkg::BYTE_W-1:0]       rdata
);

   logic [mbsb_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [mbsb_pkg::BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/mbsb_ctrl.sv
`timescale 1ns / 1ps
// Operation sequencer: clear sweep, draw read-modify-write walk, byte read, result register.
// Depends on mbsb_pkg, the channel interfaces and the framebuffer store ports.
module mbsb_ctrl #(
   parameter int FB_BYTES = mbsb_pkg::FB_BYTES_DEF,
   parameter int AW       = $clog2(FB_BYTES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mbsb_pkg::csr_regs_type            regs,
   mbsb_req_if.sink                          req_ch,
   mbsb_rsp_if.source                        rsp_ch,
   output logic                              mem_we,
   output logic [AW-1:0]                     mem_waddr,
   output logic [mbsb_pkg::BYTE_W-1:0]       mem_wdata,
   output logic                              mem_re,
   output logic [AW-1:0]                     mem_raddr,
   input  logic [mbsb_pkg::BYTE_W-1:0]       mem_rdata
);

   localparam int CW = $clog2(FB_BYTES + 1);

   mbsb_pkg::ctrl_state_type state_ff, state_in;

   logic [mbsb_pkg::OP_W-1:0]      op_ff, op_in;
   logic [mbsb_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic [mbsb_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [mbsb_pkg::COLB_W-1:0]    colb_ff, colb_in;
   logic [mbsb_pkg::RADDR_W-1:0]   raddr_ff, raddr_in;

   logic [mbsb_pkg::BYTE_W-1:0]    res_data_ff, res_data_in;
   logic                           res_status_ff, res_status_in;

   logic [CW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]                  clr_n_ff, clr_n_in;

   logic [mbsb_pkg::WIN_W-1:0]     win_ff, win_in;
   logic                           two_rows_ff, two_rows_in;
   logic [mbsb_pkg::BX_W-1:0]      bx0_ff, bx0_in;
   logic [mbsb_pkg::YW-1:0]        y0_ff, y0_in;
   logic [mbsb_pkg::BASE_W-1:0]    base0_ff, base0_in;
   logic [mbsb_pkg::SLOT_W-1:0]    slot_ff, slot_in;

   logic                           wb_valid_ff, wb_valid_in;
   logic [AW-1:0]                  wb_addr_ff, wb_addr_in;
   logic [mbsb_pkg::BYTE_W-1:0]    wb_mask_ff, wb_mask_in;

   logic                           out_valid_ff, out_valid_in;
   logic [mbsb_pkg::BYTE_W-1:0]    out_data_ff, out_data_in;
   logic                           out_status_ff, out_status_in;

   logic [mbsb_pkg::XW-1:0]        x_scaled, base_x;
   logic [mbsb_pkg::YW-1:0]        y_scaled;
   logic [mbsb_pkg::PAT_W-1:0]     pattern;
   logic                           item_bad;

   logic                           slot_row;
   logic [1:0]                     slot_col;
   logic [mbsb_pkg::BYTE_W-1:0]    slot_mask;
   logic [mbsb_pkg::BX_W-1:0]      slot_bx;
   logic [mbsb_pkg::YROW_W-1:0]    slot_y;
   logic [mbsb_pkg::ACALC_W-1:0]   slot_addr;
   logic                           slot_ok;

   logic [mbsb_pkg::CLR_PROD_W-1:0] clr_prod;
   logic                           req_take;

   function automatic logic [mbsb_pkg::PAT_W-1:0] expand_bits(
      input logic [mbsb_pkg::BYTE_W-1:0] bits,
      input logic [1:0]                  mode
   );
      logic [mbsb_pkg::PAT_W-1:0] pat;
      pat = '0;
      for (int i = 0; i < mbsb_pkg::BYTE_W; i++) begin
         if (bits[i]) begin
            case (mode)
               mbsb_pkg::SCALE_TWO: begin
                  pat[2*i]     = 1'b1;
                  pat[2*i + 1] = 1'b1;
               end
               mbsb_pkg::SCALE_HALF: begin
                  pat[i + (i >> 1)] = 1'b1;
                  if ((i & 1) == 1) begin
                     pat[i + (i >> 1) + 1] = 1'b1;
                  end
               end
               default: pat[i] = 1'b1;
            endcase
         end
      end
      return pat;
   endfunction

   // draw item geometry
   always_comb begin
      case (regs.scale_mode)
         mbsb_pkg::SCALE_TWO: begin
            x_scaled = mbsb_pkg::XW'({colb_ff, 4'b0000});
            y_scaled = mbsb_pkg::YW'({row_ff, 1'b0});
         end
         mbsb_pkg::SCALE_HALF: begin
            x_scaled = mbsb_pkg::XW'({colb_ff, 3'b000}) + mbsb_pkg::XW'({colb_ff, 2'b00});
            y_scaled = mbsb_pkg::YW'(row_ff) + mbsb_pkg::YW'(row_ff[7:1]);
         end
         default: begin
            x_scaled = mbsb_pkg::XW'({colb_ff, 3'b000});
            y_scaled = mbsb_pkg::YW'(row_ff);
         end
      endcase
      base_x   = mbsb_pkg::XW'(regs.origin_col) + x_scaled;
      pattern  = expand_bits(byte_ff, regs.scale_mode);
      item_bad = (row_ff >= regs.src_rows) ||
                 (6'(colb_ff) >= regs.src_width_bytes);
   end

   // walk slot: three bytes per target row, two rows
   always_comb begin
      slot_row = (slot_ff >= mbsb_pkg::SLOTS_ROW);
      slot_col = slot_row ? 2'(slot_ff - mbsb_pkg::SLOTS_ROW) : slot_ff[1:0];
      case (slot_col)
         2'd0:    slot_mask = win_ff[7:0];
         2'd1:    slot_mask = win_ff[15:8];
         default: slot_mask = win_ff[23:16];
      endcase
      if (slot_row && !two_rows_ff) begin
         slot_mask = '0;
      end
      slot_bx   = bx0_ff + mbsb_pkg::BX_W'(slot_col);
      slot_y    = mbsb_pkg::YROW_W'(y0_ff) + mbsb_pkg::YROW_W'(slot_row);
      slot_addr = mbsb_pkg::ACALC_W'(base0_ff)
                + (slot_row ? mbsb_pkg::ACALC_W'(regs.row_stride_bytes)
                            : mbsb_pkg::ACALC_W'(0))
                + mbsb_pkg::ACALC_W'(slot_bx);
      slot_ok   = (slot_bx < regs.row_stride_bytes) &&
                  (slot_y < mbsb_pkg::YROW_W'(regs.fb_rows)) &&
                  (32'(slot_addr) < 32'(FB_BYTES));
   end

   assign clr_prod = mbsb_pkg::CLR_PROD_W'(regs.row_stride_bytes)
                   * mbsb_pkg::CLR_PROD_W'(regs.fb_rows);
   assign req_take = req_ch.valid && (state_ff == mbsb_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      row_in        = row_ff;
      colb_in       = colb_ff;
      raddr_in      = raddr_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_n_in      = clr_n_ff;
      win_in        = win_ff;
      two_rows_in   = two_rows_ff;
      bx0_in        = bx0_ff;
      y0_in         = y0_ff;
      base0_in      = base0_ff;
      slot_in       = slot_ff;
      wb_valid_in   = 1'b0;
      wb_addr_in    = wb_addr_ff;
      wb_mask_in    = wb_mask_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = wb_addr_ff;
      mem_wdata     = mem_rdata | wb_mask_ff;
      mem_re        = 1'b0;
      mem_raddr     = AW'(raddr_ff);

      if (wb_valid_ff) begin
         mem_we = 1'b1;
      end

      unique case (state_ff) inside
         mbsb_pkg::ST_INIT, mbsb_pkg::ST_CLR: begin
            if (clr_cnt_ff < clr_n_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = AW'(clr_cnt_ff);
               mem_wdata  = '0;
               clr_cnt_in = clr_cnt_ff + CW'(1);
            end else begin
               state_in = (state_ff == mbsb_pkg::ST_INIT) ? mbsb_pkg::ST_IDLE
                                                          : mbsb_pkg::ST_DONE;
            end
         end
         mbsb_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in         = req_ch.op;
               byte_in       = req_ch.src_byte;
               row_in        = req_ch.src_row;
               colb_in       = req_ch.src_col_byte;
               raddr_in      = req_ch.read_addr;
               res_data_in   = '0;
               res_status_in = 1'b0;
               unique case (req_ch.op)
                  mbsb_pkg::OP_CLEAR: state_in = mbsb_pkg::ST_CLR_SIZE;
                  mbsb_pkg::OP_DRAW:  state_in = mbsb_pkg::ST_DRAW_PREP;
                  mbsb_pkg::OP_READ:  state_in = mbsb_pkg::ST_RD_ISSUE;
                  default: begin
                     res_status_in = 1'b1;
                     state_in      = mbsb_pkg::ST_DONE;
                  end
               endcase
            end
         end
         mbsb_pkg::ST_CLR_SIZE: begin
            clr_cnt_in = '0;
            if (32'(clr_prod) > 32'(FB_BYTES)) begin
               clr_n_in      = CW'(FB_BYTES);
               res_status_in = 1'b1;
            end else begin
               clr_n_in = CW'(clr_prod);
            end
            state_in = mbsb_pkg::ST_CLR;
         end
         mbsb_pkg::ST_DRAW_PREP: begin
            if (item_bad) begin
               res_status_in = 1'b1;
               state_in      = mbsb_pkg::ST_DONE;
            end else begin
               win_in      = mbsb_pkg::WIN_W'(pattern) << base_x[2:0];
               two_rows_in = (regs.scale_mode == mbsb_pkg::SCALE_TWO) ||
                             ((regs.scale_mode == mbsb_pkg::SCALE_HALF) && row_ff[0]);
               bx0_in      = base_x[mbsb_pkg::XW-1:3];
               y0_in       = mbsb_pkg::YW'(regs.origin_row) + y_scaled;
               state_in    = mbsb_pkg::ST_DRAW_BASE;
            end
         end
         mbsb_pkg::ST_DRAW_BASE: begin
            base0_in = mbsb_pkg::BASE_W'(y0_ff) * mbsb_pkg::BASE_W'(regs.row_stride_bytes);
            slot_in  = '0;
            state_in = mbsb_pkg::ST_DRAW_WALK;
         end
         mbsb_pkg::ST_DRAW_WALK: begin
            if (slot_mask != '0) begin
               if (slot_ok) begin
                  mem_re      = 1'b1;
                  mem_raddr   = AW'(slot_addr);
                  wb_valid_in = 1'b1;
                  wb_addr_in  = AW'(slot_addr);
                  wb_mask_in  = slot_mask;
               end else begin
                  res_status_in = 1'b1;
               end
            end
            if (slot_ff == mbsb_pkg::SLOT_LAST) begin
               state_in = mbsb_pkg::ST_DRAW_DRAIN;
            end else begin
               slot_in = slot_ff + mbsb_pkg::SLOT_W'(1);
            end
         end
         mbsb_pkg::ST_DRAW_DRAIN: begin
            state_in = mbsb_pkg::ST_DONE;
         end
         mbsb_pkg::ST_RD_ISSUE: begin
            if (32'(raddr_ff) < 32'(FB_BYTES)) begin
               mem_re   = 1'b1;
               state_in = mbsb_pkg::ST_RD_WAIT;
            end else begin
               res_status_in = 1'b1;
               state_in      = mbsb_pkg::ST_DONE;
            end
         end
         mbsb_pkg::ST_RD_WAIT: begin
            res_data_in = mem_rdata;
            state_in    = mbsb_pkg::ST_DONE;
         end
         mbsb_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in  = 1'b1;
               out_data_in   = res_data_ff;
               out_status_in = res_status_ff;
               state_in      = mbsb_pkg::ST_IDLE;
            end
         end
         default: state_in = mbsb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbsb_pkg::ST_INIT;
         clr_cnt_ff   <= '0;
         clr_n_ff     <= CW'(FB_BYTES);
         slot_ff      <= '0;
         wb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_n_ff     <= clr_n_in;
         slot_ff      <= slot_in;
         wb_valid_ff  <= wb_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      row_ff        <= row_in;
      colb_ff       <= colb_in;
      raddr_ff      <= raddr_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      win_ff        <= win_in;
      two_rows_ff   <= two_rows_in;
      bx0_ff        <= bx0_in;
      y0_ff         <= y0_in;
      base0_ff      <= base0_in;
      wb_addr_ff    <= wb_addr_in;
      wb_mask_ff    <= wb_mask_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
   end

   assign req_ch.ready     = (state_ff == mbsb_pkg::ST_IDLE);
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_data_ff;
   assign rsp_ch.status    = out_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == mbsb_pkg::ST_DRAW_WALK ||
                       state_ff == mbsb_pkg::ST_DRAW_DRAIN))
      else $error("write-back outside draw walk");

   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (32'(wb_addr_ff) < 32'(FB_BYTES)))
      else $error("write-back address beyond store");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbsb_pkg::ST_INIT || state_ff == mbsb_pkg::ST_CLR)
         |-> (clr_cnt_ff <= clr_n_ff))
      else $error("clear sweep overran its length");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbsb_pkg::ST_DONE && out_valid_ff && !rsp_ch.ready)
         |=> (state_ff == mbsb_pkg::ST_DONE && $stable(out_data_ff)))
      else $error("result loaded over a pending word");

   assert property (@(posedge clock) disable iff (reset)
      (op_ff == mbsb_pkg::OP_READ && state_ff == mbsb_pkg::ST_RD_ISSUE)
         |=> (state_ff == mbsb_pkg::ST_RD_WAIT || res_status_ff))
      else $error("read item lost its status");

endmodule

>>> rtl/mono_bitmap_scaled_blitter.sv
`timescale 1ns / 1ps
// Draw: a six-slot read-modify-write walk over the single-port-read frame store
//   (three bytes by two target rows).
// Read: one store read. Clear: stride * rows bytes zeroed, one byte per cycle.
// One item in flight; the next is accepted while its result word still waits.
// Reset is synchronous; after it a sweep zeroes all FB_BYTES bytes
//   with no item accepted; configuration writes are taken throughout.
module mono_bitmap_scaled_blitter #(
   parameter int FB_BYTES = mbsb_pkg::FB_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mbsb_req_if.sink                            req_ch,
   mbsb_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mbsb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbsb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(FB_BYTES);

   mbsb_pkg::csr_regs_type        regs;
   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [mbsb_pkg::BYTE_W-1:0]   mem_wdata;
   logic                          mem_re;
   logic [AW-1:0]                 mem_raddr;
   logic [mbsb_pkg::BYTE_W-1:0]   mem_rdata;

   mbsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   mbsb_frame_mem #(
      .DEPTH (FB_BYTES),
      .AW    (AW)
   ) u_frame_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mbsb_ctrl #(
      .FB_BYTES (FB_BYTES),
      .AW       (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .regs      (regs),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule
